// ===== sv/uvs_pkg.sv =====
// shared types, constants and fixed-point helpers for the uv sphere mesh generator
package uvs_pkg;

    localparam int MAX_SEGMENTS = 255;
    localparam int CORDIC_STEPS = 16;

    localparam int SEG_W = 8;
    localparam logic [SEG_W-1:0] SEG_MIN   = SEG_W'(3);
    localparam logic [SEG_W-1:0] SEG_MAX   = SEG_W'(MAX_SEGMENTS);
    localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(16);

    localparam int ROW_W = 8;
    localparam int COL_W = 9;

    // item kinds, also used as the phase code
    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_INDEX  = 2'd1;
    localparam logic [1:0] KIND_IDLE   = 2'd2;

    // register map
    localparam logic REG_SEGMENT_COUNT = 1'b0;

    // divider geometry
    localparam int DIV_W   = 40;
    localparam int DEN_W   = 9;
    localparam int TEX_W   = 22;
    localparam int CNT_W   = $clog2(DIV_W + 1);
    localparam int FRAC_W  = 32;
    localparam int Q14_SH  = 14;

    // cordic
    localparam int ATAN_COUNT = 24;
    localparam int STEP_W     = $clog2(ATAN_COUNT);
    localparam logic signed [31:0] GAIN_Q30 = 32'sh26DD3B6A;
    localparam logic [31:0] ATAN_TURN [ATAN_COUNT] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic signed [17:0] ONE_Q14 = 18'sd16384;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    function automatic logic [SEG_W-1:0] clamp_seg(input logic [SEG_W-1:0] s);
        logic [SEG_W-1:0] r;
        r = s;
        if (s < SEG_MIN) r = SEG_MIN;
        if (s > SEG_MAX) r = SEG_MAX;
        return r;
    endfunction

    function automatic logic signed [15:0] clamp_q14(input logic signed [17:0] v);
        logic signed [15:0] r;
        r = v[15:0];
        if (v > ONE_Q14) r = 16'sd16384;
        if (v < -ONE_Q14) r = -16'sd16384;
        return r;
    endfunction

    function automatic logic signed [15:0] round_q46(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sh0000_2000_0000_0000;
        return clamp_q14(t[63:46]);
    endfunction

    function automatic logic signed [15:0] round_q16(input logic signed [31:0] v);
        logic signed [32:0] t;
        t = {v[31], v} + 33'sd32768;
        return clamp_q14({t[32], t[32:16]});
    endfunction

endpackage

// ===== sv/uvs_div.sv =====
// bit-serial restoring divider shared by the angle and texture coordinate steps
module uvs_div
    import uvs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [CNT_W-1:0] steps,
    output logic [DIV_W-1:0] quot,
    output unit_stat_t       stat
);

    logic [DIV_W-1:0] num_reg;
    logic [DIV_W-1:0] quot_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, num_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};
    assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                quot_reg <= '0;
                cnt_reg  <= steps;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                num_reg  <= {num_reg[DIV_W-2:0], 1'b0};
                rem_reg  <= rem_next;
                quot_reg <= {quot_reg[DIV_W-2:0], ge};
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== sv/uvs_cordic.sv =====
// iterative rotation-mode cordic giving cosine and sine of a turn fraction
module uvs_cordic
    import uvs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic signed [31:0] cos_q30,
    output logic signed [31:0] sin_q30,
    output unit_stat_t         stat
);

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;

    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic signed [31:0] z_reg;
    logic [1:0]         quad_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] atan_s;

    assign dx     = y_reg >>> step_reg;
    assign dy     = x_reg >>> step_reg;
    assign atan_s = signed'(ATAN_TURN[step_reg]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= GAIN_Q30;
                y_reg    <= '0;
                z_reg    <= {2'b00, angle[29:0]};
                quad_reg <= angle[31:30];
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (!z_reg[31]) begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_s;
                end else begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_s;
                end
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        case (quad_reg)
            QUAD_I: begin
                cos_q30 = x_reg;
                sin_q30 = y_reg;
            end
            QUAD_II: begin
                cos_q30 = -y_reg;
                sin_q30 = x_reg;
            end
            QUAD_III: begin
                cos_q30 = -x_reg;
                sin_q30 = -y_reg;
            end
            default: begin
                cos_q30 = y_reg;
                sin_q30 = -x_reg;
            end
        endcase
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== sv/uv_sphere_mesh_generator.sv =====
// top level: sequencer, shared multiplier and stream/apb ports of the uv sphere mesh generator
// Each accepted transaction on the s_ side yields exactly one transaction on the m_ side: a
// vertex while the grid of (S+1)^2 points is walked, then 2*S*(S+1) triangle-strip indices in
// serpentine order with tlast on the final one, then idle items until a restart. S is the
// segment_count register clamped to 3..255, sampled when vertex 0 is produced. After the
// accept a vertex runs a bit-serial divider pass (40 steps) and a cordic run (16 iterations)
// for each of the two angles, two multiply states and a rounding state, two divider passes
// (22 steps each) for the texture coordinates, and the output state. A strip index passes
// through the index state and the output state, an idle item only through the output state.
// s_tready is high only between transactions; the result register lets the next transaction
// start while a result waits on m_tready.
module uv_sphere_mesh_generator
    import uvs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: restart [0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // m_tdata: pos_x [15:0], pos_y [31:16], pos_z [47:32], tex_u [62:48], tex_v [77:63],
    //          vertex_index [93:78], zero pad [95:94]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,
    // m_tuser: item_kind [1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_U,
        ST_COR_U,
        ST_DIV_V,
        ST_COR_V,
        ST_MUL_X,
        ST_MUL_Z,
        ST_RND_Z,
        ST_DIV_TU,
        ST_DIV_TV,
        ST_IDX,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   go_reg;

    logic [SEG_W-1:0] segment_count_reg;
    logic [SEG_W-1:0] seg_lat_reg;
    logic [1:0]       phase_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             pair_reg;

    logic [1:0]       phase_next;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_next;
    logic             pair_next;

    logic [1:0]       wk_kind_reg;
    logic [ROW_W-1:0] wk_y_reg;
    logic [COL_W-1:0] wk_col_reg;
    logic             wk_pair_reg;
    logic             wk_last_reg;
    logic [SEG_W-1:0] wk_s_reg;

    logic [31:0]        angle_reg;
    logic signed [31:0] cu_reg;
    logic signed [31:0] su_reg;
    logic signed [31:0] sv_reg;
    logic signed [63:0] prod_reg;
    logic signed [15:0] pos_x_reg;
    logic signed [15:0] pos_y_reg;
    logic signed [15:0] pos_z_reg;
    logic [14:0]        tex_u_reg;
    logic [14:0]        tex_v_reg;
    logic [15:0]        index_reg;

    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;
    logic        m_tlast_reg;

    logic             s_acc;
    logic             restart;
    logic             out_free;
    logic             cfg_wr;
    logic [1:0]       ph;
    logic [ROW_W-1:0] row_cur;
    logic [COL_W-1:0] col_cur;
    logic             pair_cur;
    logic [SEG_W-1:0] s_use;
    logic             last_flag;

    logic             div_start;
    logic [DIV_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [CNT_W-1:0] div_steps;
    logic [DIV_W-1:0] div_quot;
    unit_stat_t       div_stat;
    logic [TEX_W-1:0] tex_num;

    logic               cor_start;
    logic signed [31:0] cor_cos;
    logic signed [31:0] cor_sin;
    unit_stat_t         cor_stat;

    logic signed [31:0] mul_a;
    logic signed [63:0] mul_p;

    logic [SEG_W:0]   w;
    logic [SEG_W-1:0] xsel;
    logic [17:0]      top_idx;
    logic [17:0]      bot_idx;
    logic [17:0]      sel_idx;

    assign s_acc    = s_tvalid & s_tready;
    assign restart  = s_tdata[0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_SEGMENT_COUNT);
    assign prdata = (paddr[2] == REG_SEGMENT_COUNT) ? {24'd0, segment_count_reg} : 32'd0;

    // counter advance for the accepted transaction
    always_comb begin
        ph       = restart ? KIND_VERTEX : phase_reg;
        row_cur  = restart ? '0 : row_reg;
        col_cur  = restart ? '0 : col_reg;
        pair_cur = restart ? 1'b0 : pair_reg;
        s_use    = seg_lat_reg;
        if (ph == KIND_VERTEX && row_cur == '0 && col_cur == '0) begin
            s_use = clamp_seg(segment_count_reg);
        end
        last_flag = ({1'b0, row_cur} + 9'd1 == {1'b0, s_use}) &&
                    (col_cur == {1'b0, s_use}) && pair_cur;
        phase_next = ph;
        row_next   = row_cur;
        col_next   = col_cur;
        pair_next  = pair_cur;
        case (ph)
            KIND_VERTEX: begin
                if (col_cur >= {1'b0, s_use}) begin
                    col_next = '0;
                    if (row_cur >= s_use) begin
                        phase_next = KIND_INDEX;
                        row_next   = '0;
                    end else begin
                        row_next = row_cur + ROW_W'(1);
                    end
                end else begin
                    col_next = col_cur + COL_W'(1);
                end
            end
            KIND_INDEX: begin
                pair_next = !pair_cur;
                if (pair_cur) begin
                    if (col_cur >= {1'b0, s_use}) begin
                        col_next = '0;
                        if ({1'b0, row_cur} + 9'd1 >= {1'b0, s_use}) begin
                            phase_next = KIND_IDLE;
                            row_next   = '0;
                        end else begin
                            row_next = row_cur + ROW_W'(1);
                        end
                    end else begin
                        col_next = col_cur + COL_W'(1);
                    end
                end
            end
            default: begin
                phase_next = ph;
            end
        endcase
    end

    // divider operand selection
    always_comb begin
        tex_num   = {wk_col_reg[SEG_W-1:0], 14'd0} + TEX_W'(wk_s_reg >> 1);
        div_num   = {tex_num, {(DIV_W - TEX_W){1'b0}}};
        div_den   = {1'b0, wk_s_reg};
        div_steps = CNT_W'(TEX_W);
        case (state_reg)
            ST_DIV_U: begin
                div_num   = {wk_col_reg[SEG_W-1:0], 32'd0} + DIV_W'(wk_s_reg >> 1);
                div_steps = CNT_W'(DIV_W);
            end
            ST_DIV_V: begin
                div_num   = {wk_y_reg, 32'd0} + DIV_W'(wk_s_reg);
                div_den   = {wk_s_reg, 1'b0};
                div_steps = CNT_W'(DIV_W);
            end
            ST_DIV_TV: begin
                tex_num = {wk_y_reg, 14'd0} + TEX_W'(wk_s_reg >> 1);
                div_num = {tex_num, {(DIV_W - TEX_W){1'b0}}};
            end
            default: begin
                div_steps = CNT_W'(TEX_W);
            end
        endcase
    end

    assign div_start = go_reg && (state_reg == ST_DIV_U || state_reg == ST_DIV_V ||
                                  state_reg == ST_DIV_TU || state_reg == ST_DIV_TV);
    assign cor_start = go_reg && (state_reg == ST_COR_U || state_reg == ST_COR_V);

    uvs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .steps   (div_steps),
        .quot    (div_quot),
        .stat    (div_stat)
    );

    uvs_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .angle   (angle_reg),
        .cos_q30 (cor_cos),
        .sin_q30 (cor_sin),
        .stat    (cor_stat)
    );

    // shared multiplier
    assign mul_a = (state_reg == ST_MUL_X) ? cu_reg : su_reg;
    assign mul_p = 64'(mul_a) * 64'(sv_reg);

    // strip index
    assign w       = {1'b0, wk_s_reg} + 9'd1;
    assign xsel    = wk_y_reg[0] ? (wk_s_reg - wk_col_reg[SEG_W-1:0]) : wk_col_reg[SEG_W-1:0];
    assign top_idx = 18'(wk_y_reg) * 18'(w) + 18'(xsel);
    assign bot_idx = top_idx + 18'(w);
    assign sel_idx = (wk_y_reg[0] ^ wk_pair_reg) ? bot_idx : top_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            go_reg            <= 1'b0;
            segment_count_reg <= SEG_RESET;
            seg_lat_reg       <= SEG_RESET;
            phase_reg         <= KIND_VERTEX;
            row_reg           <= '0;
            col_reg           <= '0;
            pair_reg          <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            go_reg <= 1'b0;
            if (cfg_wr) begin
                segment_count_reg <= pwdata[SEG_W-1:0];
            end
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        phase_reg   <= phase_next;
                        row_reg     <= row_next;
                        col_reg     <= col_next;
                        pair_reg    <= pair_next;
                        seg_lat_reg <= s_use;
                        wk_kind_reg <= ph;
                        wk_y_reg    <= row_cur;
                        wk_col_reg  <= col_cur;
                        wk_pair_reg <= pair_cur;
                        wk_last_reg <= last_flag;
                        wk_s_reg    <= s_use;
                        case (ph)
                            KIND_VERTEX: begin
                                state_reg <= ST_DIV_U;
                                go_reg    <= 1'b1;
                            end
                            KIND_INDEX: begin
                                state_reg <= ST_IDX;
                            end
                            default: begin
                                state_reg <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_DIV_U: begin
                    if (div_stat.done) begin
                        angle_reg <= div_quot[FRAC_W-1:0];
                        state_reg <= ST_COR_U;
                        go_reg    <= 1'b1;
                    end
                end
                ST_COR_U: begin
                    if (cor_stat.done) begin
                        cu_reg    <= cor_cos;
                        su_reg    <= cor_sin;
                        state_reg <= ST_DIV_V;
                        go_reg    <= 1'b1;
                    end
                end
                ST_DIV_V: begin
                    if (div_stat.done) begin
                        angle_reg <= div_quot[FRAC_W-1:0];
                        state_reg <= ST_COR_V;
                        go_reg    <= 1'b1;
                    end
                end
                ST_COR_V: begin
                    if (cor_stat.done) begin
                        pos_y_reg <= round_q16(cor_cos);
                        sv_reg    <= cor_sin;
                        state_reg <= ST_MUL_X;
                    end
                end
                ST_MUL_X: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL_Z;
                end
                ST_MUL_Z: begin
                    pos_x_reg <= round_q46(prod_reg);
                    prod_reg  <= mul_p;
                    state_reg <= ST_RND_Z;
                end
                ST_RND_Z: begin
                    pos_z_reg <= round_q46(prod_reg);
                    state_reg <= ST_DIV_TU;
                    go_reg    <= 1'b1;
                end
                ST_DIV_TU: begin
                    if (div_stat.done) begin
                        tex_u_reg <= div_quot[Q14_SH:0];
                        state_reg <= ST_DIV_TV;
                        go_reg    <= 1'b1;
                    end
                end
                ST_DIV_TV: begin
                    if (div_stat.done) begin
                        tex_v_reg <= div_quot[Q14_SH:0];
                        state_reg <= ST_EMIT;
                    end
                end
                ST_IDX: begin
                    index_reg <= sel_idx[15:0];
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= wk_kind_reg;
                        m_tdata_reg  <= '0;
                        m_tlast_reg  <= 1'b0;
                        case (wk_kind_reg)
                            KIND_VERTEX: begin
                                m_tdata_reg[15:0]  <= pos_x_reg;
                                m_tdata_reg[31:16] <= pos_y_reg;
                                m_tdata_reg[47:32] <= pos_z_reg;
                                m_tdata_reg[62:48] <= tex_u_reg;
                                m_tdata_reg[77:63] <= tex_v_reg;
                            end
                            KIND_INDEX: begin
                                m_tdata_reg[93:78] <= index_reg;
                                m_tlast_reg        <= wk_last_reg;
                            end
                            default: begin
                                m_tlast_reg <= 1'b0;
                            end
                        endcase
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_IDLE |-> m_tdata == '0 && !m_tlast)
        else $error("idle item carries data");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == KIND_INDEX)
        else $error("tlast on a non-index item");

    a_seg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_lat_reg >= SEG_MIN)
        else $error("latched segment count below minimum");

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(div_stat.busy && cor_stat.busy))
        else $error("divider and cordic busy together");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_VERTEX |->
            $signed(m_tdata[15:0]) <= 16'sd16384 && $signed(m_tdata[15:0]) >= -16'sd16384)
        else $error("pos_x out of range");

endmodule

// ===== dv/tb_uv_sphere_mesh_generator.sv =====
`timescale 1ns / 1ps
// testbench for the uv sphere mesh generator, checked against a cordic mesh predictor
module tb_uv_sphere_mesh_generator;
    import uvs_pkg::*;

    localparam int          TURN_STEPS   = CORDIC_STEPS;
    localparam longint      TURN_GAIN    = 64'sd652032874;
    localparam int unsigned LIMIT        = 2_000_000;
    localparam int unsigned PHASE_ITEMS  = 487;
    localparam logic [2:0]  SEG_ADDR     = {REG_SEGMENT_COUNT, 2'b00};
    localparam logic [2:0]  UNUSED_ADDR  = 3'd4;
    localparam logic [31:0] ATAN_STEP [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [14:0]        tex_u;
        logic [14:0]        tex_v;
        logic [15:0]        vidx;
        logic               last;
    } mesh_item_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    uv_sphere_mesh_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bit          restart_queue [$];
    mesh_item_t  mesh_items_due [$];
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;

    // predictor state
    logic [7:0]  seg_reg     = SEG_RESET;
    logic [1:0]  mesh_phase  = KIND_VERTEX;
    int unsigned grid_row    = 0;
    int unsigned grid_col    = 0;
    bit          strip_half  = 1'b0;
    int unsigned seg_in_use  = 16;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned clamp_segments(input logic [7:0] raw);
        int unsigned s;
        s = raw;
        if (s < 3) s = 3;
        if (s > MAX_SEGMENTS) s = MAX_SEGMENTS;
        return s;
    endfunction

    function automatic void turn_to_cos_sin(input logic [31:0] turn, output longint c,
                                            output longint s);
        longint x, y, z, dx, dy, step;
        x = TURN_GAIN;
        y = 0;
        z = {34'd0, turn[29:0]};
        for (int i = 0; i < TURN_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            step = {32'd0, ATAN_STEP[i]};
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - step;
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + step;
            end
        end
        case (turn[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic logic signed [15:0] q14_round(input longint v, input int sh);
        longint r;
        r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    function automatic mesh_item_t mesh_step(input logic restart);
        mesh_item_t  it;
        logic [63:0] turn_u, turn_v;
        longint      cu, su, cv, sv;
        int unsigned s, w, xc, top, bot, idx;
        it = '0;
        if (restart) begin
            mesh_phase = KIND_VERTEX;
            grid_row   = 0;
            grid_col   = 0;
            strip_half = 1'b0;
        end
        case (mesh_phase)
            KIND_VERTEX: begin
                if (grid_row == 0 && grid_col == 0) seg_in_use = clamp_segments(seg_reg);
                s = seg_in_use;
                turn_u = ((64'(grid_col) << 32) + 64'(s / 2)) / 64'(s);
                turn_v = ((64'(grid_row) << 32) + 64'(s)) / 64'(2 * s);
                turn_to_cos_sin(turn_u[31:0], cu, su);
                turn_to_cos_sin(turn_v[31:0], cv, sv);
                it.kind  = KIND_VERTEX;
                it.pos_x = q14_round(cu * sv, 46);
                it.pos_y = q14_round(cv, 16);
                it.pos_z = q14_round(su * sv, 46);
                it.tex_u = 15'((grid_col * 16384 + s / 2) / s);
                it.tex_v = 15'((grid_row * 16384 + s / 2) / s);
                if (grid_col >= s) begin
                    grid_col = 0;
                    if (grid_row >= s) begin
                        mesh_phase = KIND_INDEX;
                        grid_row   = 0;
                    end else begin
                        grid_row++;
                    end
                end else begin
                    grid_col++;
                end
            end
            KIND_INDEX: begin
                s = seg_in_use;
                w = s + 1;
                xc = grid_row[0] ? s - grid_col : grid_col;
                top = grid_row * w + xc;
                bot = (grid_row + 1) * w + xc;
                if (grid_row[0]) idx = strip_half ? top : bot;
                else idx = strip_half ? bot : top;
                it.kind = KIND_INDEX;
                it.vidx = idx[15:0];
                it.last = (grid_row + 1 == s) && (grid_col == s) && strip_half;
                if (!strip_half) begin
                    strip_half = 1'b1;
                end else begin
                    strip_half = 1'b0;
                    if (grid_col >= s) begin
                        grid_col = 0;
                        if (grid_row + 1 >= s) begin
                            mesh_phase = KIND_IDLE;
                            grid_row   = 0;
                        end else begin
                            grid_row++;
                        end
                    end else begin
                        grid_col++;
                    end
                end
            end
            default: begin
                it.kind = KIND_IDLE;
            end
        endcase
        return it;
    endfunction

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
        end else begin
            if (s_tvalid && s_tready) begin
                mesh_items_due.insert(mesh_items_due.size(), mesh_step(s_tdata[0]));
            end
            if (!s_tvalid || s_tready) begin
                if (restart_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    s_tdata  <= {7'd0, restart_queue.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        mesh_item_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (mesh_items_due.size() == 0) begin
                    $error("result transaction with no item pending");
                    fail_count++;
                end else begin
                    want = mesh_items_due.pop_front();
                    check_field("item_kind", want.kind, m_tuser);
                    check_field("pos_x", longint'($signed(want.pos_x)),
                                longint'($signed(m_tdata[15:0])));
                    check_field("pos_y", longint'($signed(want.pos_y)),
                                longint'($signed(m_tdata[31:16])));
                    check_field("pos_z", longint'($signed(want.pos_z)),
                                longint'($signed(m_tdata[47:32])));
                    check_field("tex_u", want.tex_u, m_tdata[62:48]);
                    check_field("tex_v", want.tex_v, m_tdata[77:63]);
                    check_field("vertex_index", want.vidx, m_tdata[93:78]);
                    check_field("zero pad", 0, m_tdata[95:94]);
                    check_field("last", want.last, m_tlast);
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("tb_uv_sphere_mesh_generator NOT OK");
            $finish;
        end
    end

    task automatic queue_run(input bit first_restart, input int unsigned n,
                             input int unsigned noise_pct);
        for (int unsigned i = 0; i < n; i++) begin
            if (i == 0) restart_queue.insert(restart_queue.size(), first_restart);
            else restart_queue.insert(restart_queue.size(), $urandom_range(99) < noise_pct);
        end
    endtask

    // sampled away from the rising edge so the driver and monitor updates are settled
    task automatic wait_mesh_drained();
        do @(negedge aclk);
        while (restart_queue.size() != 0 || s_tvalid || mesh_items_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // a read compares prdata with the register image
    task automatic apb_access(input bit is_write, input logic [2:0] addr,
                              input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        if (is_write && addr == SEG_ADDR) seg_reg = data[7:0];
        if (!is_write) check_field("segment_count", {24'd0, seg_reg}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_segments(input logic [31:0] data);
        apb_access(1'b1, SEG_ADDR, data);
        apb_access(1'b0, SEG_ADDR, 32'd0);
    endtask

    initial begin : stimulus
        int unsigned idle_tbl [4];
        int unsigned stall_tbl [4];
        int unsigned sent, pick, eff, full, len, cut, noise;
        logic [31:0] wdata;
        idle_tbl  = '{0, 72, 0, 34};
        stall_tbl = '{0, 0, 72, 34};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // first steps after reset with the reset segment count
        queue_run(1'b0, 3, 0);
        wait_mesh_drained();
        // count below the minimum, written mid-mesh: latched count stays
        set_segments(32'd0);
        queue_run(1'b0, 2, 0);
        wait_mesh_drained();
        apb_access(1'b1, UNUSED_ADDR, 32'hFFFF_FFFF);
        apb_access(1'b0, SEG_ADDR, 32'd0);
        // back-to-back restarts
        queue_run(1'b1, 1, 0);
        queue_run(1'b1, 3, 0);
        wait_mesh_drained();
        set_segments(32'hFFFF_FFFF);
        queue_run(1'b1, 5, 0);
        wait_mesh_drained();
        set_segments(32'd2);
        queue_run(1'b1, 2, 0);
        wait_mesh_drained();
        set_segments(32'd1);
        queue_run(1'b1, 2, 0);
        wait_mesh_drained();

        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_tbl[p];
            stall_pct = stall_tbl[p];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                wdata = $urandom;
                if (pick < 12) wdata[7:0] = 8'($urandom_range(2));
                else if (pick < 22) wdata[7:0] = 8'($urandom_range(255, 7));
                else wdata[7:0] = 8'($urandom_range(6, 3));
                if ($urandom_range(9) == 0) apb_access(1'b1, UNUSED_ADDR, $urandom);
                set_segments(wdata);
                eff  = clamp_segments(wdata[7:0]);
                full = (eff + 1) * (eff + 1) + 2 * eff * (eff + 1);
                if (eff <= 6 && $urandom_range(9) != 0) begin
                    len   = full + $urandom_range(4);
                    noise = 0;
                end else begin
                    len   = $urandom_range(30, 1);
                    noise = 10;
                end
                cut = len;
                if (len > 1 && $urandom_range(4) == 0) cut = $urandom_range(len - 1, 1);
                queue_run(1'b1, cut, noise);
                if (cut < len) begin
                    // rewrite the count while a mesh is under way
                    wait_mesh_drained();
                    set_segments($urandom);
                    queue_run(1'b0, len - cut, noise);
                end
                sent += len;
                wait_mesh_drained();
            end
        end

        wait_mesh_drained();
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && mesh_items_due.size() == 0) begin
            $display("tb_uv_sphere_mesh_generator OK");
        end else begin
            $display("tb_uv_sphere_mesh_generator NOT OK");
        end
        $finish;
    end

endmodule
